FILE: rtl/vector_magnitude_integer_sqrt_defines.svh
// Assertion macros shared by the vector magnitude RTL.
`ifndef VECTOR_MAGNITUDE_INTEGER_SQRT_DEFINES_SVH
`define VECTOR_MAGNITUDE_INTEGER_SQRT_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define VMSQRT_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define VMSQRT_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/vmsqrt_pkg.sv
// Shared constants and the cell data type for the vector magnitude block.
`default_nettype none

package vmsqrt_pkg;

  // Significant width of each coordinate; the ports are always FIELD_W wide.
  localparam int COORD_WIDTH = 32;
  localparam int FIELD_W     = 32;
  localparam int MAG_W       = 32;

  // Sum of squares, partial remainder and number of root cells.
  localparam int SUM_W   = 2 * COORD_WIDTH;
  localparam int REM_W   = COORD_WIDTH + 2;
  localparam int N_CELLS = COORD_WIDTH;

  // Data handed from one root cell to the next.
  typedef struct packed {
    logic                   valid;
    logic [SUM_W-1:0]       rad;
    logic [REM_W-1:0]       rem;
    logic [COORD_WIDTH-1:0] root;
  } cell_t;

endpackage

`default_nettype wire

FILE: rtl/vector_magnitude_integer_sqrt.sv
// Top level of the integer vector magnitude block: floor(sqrt(x*x + y*y)).
//
//  channel   direction  handshake            payload
//  request   in         start, busy          x_coord, y_coord (signed, 32 bits each)
//  result    out        done (one cycle)     magnitude (unsigned, 32 bits)
//
// A request is taken at a rising edge where start is high and busy is low.
// The front end registers absolute values at that edge, then the squares, then
// their sum; a row of COORD_WIDTH root cells then settles one result bit per
// cycle, and done rises as the request leaves the last cell; the result is
// taken at the next rising edge.
// Only one request is in flight: busy drops in the cycle done is shown, so a new
// request can be taken then; none is taken before the current result is shown.
// Reset (synchronous, active high) clears busy and every valid flag; there is
// no stall, as the receiver takes each result in the cycle it is shown.
`default_nettype none
`include "vector_magnitude_integer_sqrt_defines.svh"

module vector_magnitude_integer_sqrt
  import vmsqrt_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [FIELD_W-1:0] x_coord,
  input  logic [FIELD_W-1:0] y_coord,
  output logic               done,
  output logic [MAG_W-1:0]   magnitude
);

  logic               accept;
  logic               busy_next;
  cell_t              chain [0:N_CELLS];
  logic [N_CELLS-1:0] chain_valid;

  assign accept = start && !busy;

  // Front end feeds the sum of squares into the first root cell.
  vmsqrt_square u_square (
    .clk     (clk),
    .rst     (rst),
    .load    (accept),
    .x_coord (x_coord),
    .y_coord (y_coord),
    .head    (chain[0])
  );

  // Each cell hands its radicand, remainder and partial root to the next.
  for (genvar i = 0; i < N_CELLS; i++) begin : g_cell
    vmsqrt_cell u_cell (
      .clk  (clk),
      .rst  (rst),
      .din  (chain[i]),
      .dout (chain[i+1])
    );
    assign chain_valid[i] = chain[i+1].valid;
  end

  // The last cell's register is the result register.
  assign done      = chain[N_CELLS].valid;
  assign magnitude = MAG_W'(chain[N_CELLS].root);

  // Busy clears when the request enters the last cell, so the next request
  // can be taken in the same cycle that the result is shown.
  always_comb begin
    busy_next = busy;
    if (accept) begin
      busy_next = 1'b1;
    end else if (chain[N_CELLS-1].valid) begin
      busy_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else begin
      busy <= busy_next;
    end
  end

  `VMSQRT_ASSERT_NEXT(a_busy_after_accept, clk, rst, accept, busy, "busy not set after request")
  `VMSQRT_ASSERT_NOW(a_done_needs_busy, clk, rst, done, $past(busy), "result without request")
  `VMSQRT_ASSERT_NOW(a_single_request, clk, rst, 1'b1, $onehot0(chain_valid), "two requests in flight")
  `VMSQRT_ASSERT_NOW(a_idle_chain_empty, clk, rst, !busy && !done, chain_valid == '0, "cells busy while idle")

endmodule

`default_nettype wire

FILE: rtl/vmsqrt_square.sv
// Front end: absolute values, squares and their sum, three register stages.
`default_nettype none

module vmsqrt_square
  import vmsqrt_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               load,
  input  logic [FIELD_W-1:0] x_coord,
  input  logic [FIELD_W-1:0] y_coord,
  output cell_t              head
);

  logic [COORD_WIDTH-1:0] x_low;
  logic [COORD_WIDTH-1:0] y_low;
  logic [COORD_WIDTH-1:0] x_abs_next;
  logic [COORD_WIDTH-1:0] y_abs_next;
  logic [COORD_WIDTH-1:0] x_abs;
  logic [COORD_WIDTH-1:0] y_abs;
  logic [SUM_W-1:0]       x_sq_next;
  logic [SUM_W-1:0]       y_sq_next;
  logic [SUM_W-1:0]       x_sq;
  logic [SUM_W-1:0]       y_sq;
  logic [SUM_W-1:0]       sum;
  logic                   abs_valid;
  logic                   sq_valid;
  logic                   sum_valid;

  // Bits above the coordinate width are ignored; the rest is two's complement.
  assign x_low = x_coord[COORD_WIDTH-1:0];
  assign y_low = y_coord[COORD_WIDTH-1:0];

  // The most negative value maps to its true magnitude as an unsigned number.
  assign x_abs_next = x_low[COORD_WIDTH-1] ? COORD_WIDTH'(~x_low + 1'b1) : x_low;
  assign y_abs_next = y_low[COORD_WIDTH-1] ? COORD_WIDTH'(~y_low + 1'b1) : y_low;

  assign x_sq_next = SUM_W'(x_abs) * SUM_W'(x_abs);
  assign y_sq_next = SUM_W'(y_abs) * SUM_W'(y_abs);

  always_ff @(posedge clk) begin
    if (rst) begin
      abs_valid <= 1'b0;
      sq_valid  <= 1'b0;
      sum_valid <= 1'b0;
    end else begin
      abs_valid <= load;
      sq_valid  <= abs_valid;
      sum_valid <= sq_valid;
    end
    x_abs <= x_abs_next;
    y_abs <= y_abs_next;
    x_sq  <= x_sq_next;
    y_sq  <= y_sq_next;
    sum   <= x_sq + y_sq;
  end

  always_comb begin
    head.valid = sum_valid;
    head.rad   = sum;
    head.rem   = '0;
    head.root  = '0;
  end

endmodule

`default_nettype wire

FILE: rtl/vmsqrt_cell.sv
// One root cell: settles one result bit from two radicand bits.
`default_nettype none

module vmsqrt_cell
  import vmsqrt_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  cell_t din,
  output cell_t dout
);

  logic [REM_W+1:0] acc;
  logic [REM_W+1:0] trial;
  logic [REM_W+1:0] diff;
  logic             fits;
  cell_t            stage;

  // Bring down the next two radicand bits and test the trial divisor 4q+1.
  assign acc   = {din.rem, din.rad[SUM_W-1:SUM_W-2]};
  assign trial = (REM_W + 2)'({din.root, 2'b01});
  assign fits  = acc >= trial;
  assign diff  = acc - trial;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage.valid <= 1'b0;
    end else begin
      stage.valid <= din.valid;
    end
    stage.rad  <= {din.rad[SUM_W-3:0], 2'b00};
    stage.rem  <= fits ? diff[REM_W-1:0] : acc[REM_W-1:0];
    stage.root <= {din.root[COORD_WIDTH-2:0], fits};
  end

  assign dout = stage;

endmodule

`default_nettype wire
